>>> sv/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed.");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");

// Same-cycle implication that is also checked while reset is high.
`define ASSERT_IMPL_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("Assertion failed.");

`endif

>>> sv/rrsl_pkg.sv
// Package with the item types, operation codes and sequencer states of the ring lookup unit.
package rrsl_pkg;

   localparam int OP_W    = 2;
   localparam int SEQNO_W = 32;
   localparam int POS_W   = 16;
   localparam int SLOT_W  = 6;
   localparam int CSR_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_GET    = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SEQNO_W-1:0] seqno;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DIV,
      ST_POS,
      ST_ADD,
      ST_COMPARE
   } state_type;

endpackage

>>> sv/retransmit_ring_seqno_lookup_unit.sv
// Top level of the retransmission ring with sequence number lookup.
//
// An item is taken at a clock edge where start is high and busy is low. Each item
// gives exactly one result on rsp_item, shown for one cycle with rsp_strobe high.
// The receiver cannot hold results off, and none is needed: a result is shown
// while the unit is idle again, so the next item may start in that same cycle.
// An append, an unknown operation and a lookup on an empty ring answer in the cycle
// after they are taken. A positional read, and a lookup whose distance from the
// front tag is not negative, run the shared restoring modulo unit, which retires
// one dividend bit per cycle over DIV_W bits, where DIV_W is the larger of SEQ_BITS
// and the position sum width. The slot count register is written over the csr
// channel while the unit is idle; a write empties the ring. After reset the ring is
// empty and the slot count is the smaller of 64 and MAX_SLOTS. The tag memory is
// not cleared; per-slot written bits guard it.
module retransmit_ring_seqno_lookup_unit #(
   parameter int MAX_SLOTS = 64,
   parameter int SEQ_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rrsl_pkg::req_type                    req_item,
   output logic                                 rsp_strobe,
   output rrsl_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrsl_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CAP_W     = $clog2(MAX_SLOTS + 1);
   localparam int T_W       = IDX_W + 1;
   localparam int POS_SUM_W = ((IDX_W > rrsl_pkg::POS_W) ? IDX_W : rrsl_pkg::POS_W) + 1;
   localparam int DIV_W     = (SEQ_BITS > POS_SUM_W) ? SEQ_BITS : POS_SUM_W;
   localparam int CNT_W     = $clog2(DIV_W);
   localparam int RESET_CAP = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

   rrsl_pkg::state_type     state_ff, state_in;
   logic [rrsl_pkg::OP_W-1:0] op_ff, op_in;
   logic [SEQ_BITS-1:0]     seq_ff, seq_in;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [IDX_W-1:0]        back_ff, back_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic [MAX_SLOTS-1:0]    written_ff, written_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [IDX_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rrsl_pkg::rsp_type       rsp_ff, rsp_in;

   logic [SEQ_BITS-1:0]     tag_mem [MAX_SLOTS];
   logic [SEQ_BITS-1:0]     rdata_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   logic [SEQ_BITS-1:0]     item_seq;
   logic [SEQ_BITS-1:0]     diff;
   logic [T_W-1:0]          cap_ext;
   logic [T_W-1:0]          back_inc;
   logic [T_W-1:0]          front_inc;
   logic [T_W-1:0]          trial;
   logic [T_W-1:0]          idx_sum;
   logic [IDX_W-1:0]        back_next;
   logic [IDX_W-1:0]        front_next;
   logic                    occupied;

   assign busy       = (state_ff != rrsl_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == rrsl_pkg::ST_IDLE) && !start;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   assign cap_ext   = T_W'(cap_ff);
   assign item_seq  = SEQ_BITS'(req_item.seqno);
   assign back_inc  = T_W'(back_ff) + T_W'(1);
   assign back_next = (back_inc == cap_ext) ? '0 : IDX_W'(back_inc);
   assign front_inc = T_W'(front_ff) + T_W'(1);
   assign front_next = (front_inc == cap_ext) ? '0 : IDX_W'(front_inc);
   assign diff      = seq_ff - rdata_ff;
   assign trial     = {rem_ff, div_ff[DIV_W-1]};
   assign idx_sum   = T_W'(front_ff) + T_W'(rem_ff);
   assign occupied  = (front_ff <= back_ff) ?
                      ((rem_ff >= front_ff) && (rem_ff < back_ff)) :
                      !((rem_ff >= back_ff) && (rem_ff < front_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rrsl_pkg::ST_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         cap_ff        <= CAP_W'(RESET_CAP);
         written_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         back_ff       <= back_in;
         cap_ff        <= cap_in;
         written_ff    <= written_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      seq_ff <= seq_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[back_ff] <= item_seq;
      end
      rdata_ff <= tag_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      seq_in        = seq_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      cap_in        = cap_ff;
      written_in    = written_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = front_ff;
      mem_we        = 1'b0;

      case (state_ff)
         rrsl_pkg::ST_IDLE: begin
            if (start) begin
               op_in  = req_item.op;
               seq_in = item_seq;
               rsp_in = '0;
               case (req_item.op)
                  rrsl_pkg::OP_APPEND: begin
                     mem_we              = 1'b1;
                     written_in[back_ff] = 1'b1;
                     rsp_in.found        = 1'b1;
                     rsp_in.slot         = rrsl_pkg::SLOT_W'(back_ff);
                     rsp_strobe_in       = 1'b1;
                     back_in             = back_next;
                     if (back_next == front_ff) begin
                        front_in = front_next;
                     end
                  end
                  rrsl_pkg::OP_GET: begin
                     div_in   = DIV_W'(POS_SUM_W'(front_ff) + POS_SUM_W'(req_item.position));
                     rem_in   = '0;
                     cnt_in   = CNT_W'(DIV_W - 1);
                     state_in = rrsl_pkg::ST_DIV;
                  end
                  rrsl_pkg::OP_LOOKUP: begin
                     if (front_ff == back_ff) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = rrsl_pkg::ST_DIFF;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end else if (csr_valid) begin
               if (csr_wdata == '0) begin
                  cap_in = CAP_W'(1);
               end else if (int'(csr_wdata) > MAX_SLOTS) begin
                  cap_in = CAP_W'(MAX_SLOTS);
               end else begin
                  cap_in = CAP_W'(csr_wdata);
               end
               front_in   = '0;
               back_in    = '0;
               written_in = '0;
            end
         end
         rrsl_pkg::ST_DIFF: begin
            if (diff[SEQ_BITS-1]) begin
               rsp_in        = '0;
               rsp_strobe_in = 1'b1;
               state_in      = rrsl_pkg::ST_IDLE;
            end else begin
               div_in   = DIV_W'(diff);
               rem_in   = '0;
               cnt_in   = CNT_W'(DIV_W - 1);
               state_in = rrsl_pkg::ST_DIV;
            end
         end
         rrsl_pkg::ST_DIV: begin
            if (trial >= cap_ext) begin
               rem_in = IDX_W'(trial - cap_ext);
            end else begin
               rem_in = IDX_W'(trial);
            end
            div_in = div_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = (op_ff == rrsl_pkg::OP_LOOKUP) ? rrsl_pkg::ST_ADD : rrsl_pkg::ST_POS;
            end
         end
         rrsl_pkg::ST_POS: begin
            rsp_in = '0;
            if (occupied) begin
               rsp_in.found = 1'b1;
               rsp_in.slot  = rrsl_pkg::SLOT_W'(rem_ff);
            end
            rsp_strobe_in = 1'b1;
            state_in      = rrsl_pkg::ST_IDLE;
         end
         rrsl_pkg::ST_ADD: begin
            if (idx_sum >= cap_ext) begin
               idx_in = IDX_W'(idx_sum - cap_ext);
            end else begin
               idx_in = IDX_W'(idx_sum);
            end
            rd_addr  = idx_in;
            state_in = rrsl_pkg::ST_COMPARE;
         end
         rrsl_pkg::ST_COMPARE: begin
            rsp_in = '0;
            if (written_ff[idx_ff] && (rdata_ff == seq_ff)) begin
               rsp_in.found = 1'b1;
               rsp_in.slot  = rrsl_pkg::SLOT_W'(idx_ff);
            end
            rsp_strobe_in = 1'b1;
            state_in      = rrsl_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrsl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/rrsl_checker.sv
// Port-level checker for the ring lookup unit and its bind to the top level.
`include "assert_macros.svh"

module rrsl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input rrsl_pkg::rsp_type rsp_item,
   input logic              csr_ready
);

   // An accepted item either answers at once or keeps the unit busy.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)

   // Leaving the busy phase always delivers the result of that item.
   `ASSERT_IMPL(a_busy_end_result, clock, reset, $fell(busy), rsp_strobe)

   // A miss never reports a slot.
   `ASSERT_IMPL(a_miss_slot_zero, clock, reset, rsp_strobe && !rsp_item.found, rsp_item.slot == '0)

   // Register writes are only offered while no item is in flight.
   `ASSERT_IMPL(a_csr_when_idle, clock, reset, csr_ready, !busy)

   // Reset leaves the unit idle with no result pending.
   `ASSERT_IMPL_ALWAYS(a_reset_quiet, clock, $past(reset), !busy && !rsp_strobe)

endmodule

bind retransmit_ring_seqno_lookup_unit rrsl_checker u_rrsl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item),
   .csr_ready  (csr_ready)
);

>>> dv/retransmit_ring_seqno_lookup_unit_tb.sv
// Self-checking testbench for the retransmission ring with sequence number lookup.
`timescale 1ns / 1ps

module retransmit_ring_seqno_lookup_unit_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int RING_DEPTH    = 64;

   typedef enum logic [1:0] {
      PEND_ITEM,
      PEND_CSR,
      PEND_DRAIN
   } pend_kind_type;

   typedef struct {
      pend_kind_type                  kind;
      rrsl_pkg::req_type              req;
      logic [rrsl_pkg::CSR_W-1:0]     csr_value;
      int unsigned                    hold;
   } pend_entry_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   rrsl_pkg::req_type          req_item = '0;
   logic                       rsp_strobe;
   rrsl_pkg::rsp_type          rsp_item;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [rrsl_pkg::CSR_W-1:0] csr_wdata = '0;

   pend_entry_type    ops_to_send[$];
   rrsl_pkg::rsp_type slot_answers_due[$];

   logic [rrsl_pkg::SEQNO_W-1:0] ring_tags [RING_DEPTH];
   logic                         ring_written [RING_DEPTH];
   logic [rrsl_pkg::SLOT_W-1:0]  ring_front;
   logic [rrsl_pkg::SLOT_W-1:0]  ring_back;
   logic [rrsl_pkg::CSR_W-1:0]   ring_slots_reg;

   int          issued_count   = 0;
   int          answered_count = 0;
   int          mismatch_count = 0;
   int          hit_count      = 0;
   int          csr_writes     = 0;
   int          op_tally [4]   = '{0, 0, 0, 0};
   int unsigned hold_count     = 0;
   int unsigned cycle_count    = 0;
   bit          allow_idle     = 1'b1;

   retransmit_ring_seqno_lookup_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rrsl_pkg::rsp_type ring_predict(input rrsl_pkg::req_type r);
      rrsl_pkg::rsp_type            answer;
      int unsigned                  cap;
      int unsigned                  f;
      int unsigned                  b;
      int unsigned                  idx;
      bit                           in_span;
      logic [rrsl_pkg::SEQNO_W-1:0] diff;
      answer = '0;
      if (ring_slots_reg == 0) cap = 1;
      else if (ring_slots_reg > RING_DEPTH) cap = RING_DEPTH;
      else cap = 32'(ring_slots_reg);
      f = ring_front % cap;
      b = ring_back % cap;
      case (r.op)
         rrsl_pkg::OP_APPEND: begin
            ring_tags[b]    = r.seqno;
            ring_written[b] = 1'b1;
            answer.found    = 1'b1;
            answer.slot     = b[rrsl_pkg::SLOT_W-1:0];
            b = (b + 1) % cap;
            if (b == f) f = (f + 1) % cap;
         end
         rrsl_pkg::OP_GET: begin
            idx = (f + r.position) % cap;
            if (f <= b) in_span = (idx >= f) && (idx < b);
            else in_span = !((idx >= b) && (idx < f));
            if (in_span) begin
               answer.found = 1'b1;
               answer.slot  = idx[rrsl_pkg::SLOT_W-1:0];
            end
         end
         rrsl_pkg::OP_LOOKUP: begin
            if (f != b) begin
               diff = r.seqno - ring_tags[f];
               if (!diff[rrsl_pkg::SEQNO_W-1]) begin
                  idx = (f + diff % cap) % cap;
                  if (ring_written[idx] && ring_tags[idx] == r.seqno) begin
                     answer.found = 1'b1;
                     answer.slot  = idx[rrsl_pkg::SLOT_W-1:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      ring_front = f[rrsl_pkg::SLOT_W-1:0];
      ring_back  = b[rrsl_pkg::SLOT_W-1:0];
      return answer;
   endfunction

   task automatic queue_op(input logic [rrsl_pkg::OP_W-1:0] op,
                           input logic [rrsl_pkg::SEQNO_W-1:0] seqno,
                           input logic [rrsl_pkg::POS_W-1:0] position);
      pend_entry_type e;
      e.kind         = PEND_ITEM;
      e.req.op       = op;
      e.req.seqno    = seqno;
      e.req.position = position;
      e.csr_value    = '0;
      e.hold         = (allow_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      ops_to_send.push_back(e);
   endtask

   task automatic queue_csr(input logic [rrsl_pkg::CSR_W-1:0] value);
      pend_entry_type e;
      e.kind      = PEND_CSR;
      e.req       = '0;
      e.csr_value = value;
      e.hold      = 0;
      ops_to_send.push_back(e);
   endtask

   task automatic queue_drain();
      pend_entry_type e;
      e.kind      = PEND_DRAIN;
      e.req       = '0;
      e.csr_value = '0;
      e.hold      = 0;
      ops_to_send.push_back(e);
   endtask

   // Mostly runs of appends with lookups and reads near the live window, plus some noise.
   task automatic fill_phase(input int unsigned slots_val, input int unsigned n_items);
      int unsigned                  cap;
      int unsigned                  pick;
      logic [rrsl_pkg::SEQNO_W-1:0] next_seq;
      logic [rrsl_pkg::SEQNO_W-1:0] probe;
      queue_csr(slots_val[rrsl_pkg::CSR_W-1:0]);
      if (slots_val == 0) cap = 1;
      else if (slots_val > RING_DEPTH) cap = RING_DEPTH;
      else cap = slots_val;
      next_seq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_op(rrsl_pkg::OP_APPEND, next_seq,
                     rrsl_pkg::POS_W'($urandom_range(0, 65535)));
            next_seq = next_seq + (($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 1);
         end else if (pick < 65) begin
            probe = next_seq - $urandom_range(0, cap + 3);
            queue_op(rrsl_pkg::OP_LOOKUP, probe, rrsl_pkg::POS_W'($urandom_range(0, 65535)));
         end else if (pick < 80) begin
            queue_op(rrsl_pkg::OP_GET, $urandom, rrsl_pkg::POS_W'($urandom_range(0, cap + 2)));
         end else begin
            queue_op(rrsl_pkg::OP_W'($urandom_range(0, 3)), $urandom,
                     rrsl_pkg::POS_W'($urandom_range(0, 65535)));
         end
         if ($urandom_range(0, 40) == 0) queue_drain();
      end
   endtask

   always @(posedge clock) begin
      logic nxt_start;
      logic nxt_csr;
      int   answers_left;
      nxt_start = start;
      nxt_csr   = csr_valid;
      if (reset) begin
         nxt_start      = 1'b0;
         nxt_csr        = 1'b0;
         hold_count     = 0;
         ring_front     = '0;
         ring_back      = '0;
         ring_slots_reg = 7'd64;
         foreach (ring_written[k]) ring_written[k] = 1'b0;
      end else begin
         if (start && !busy) begin
            slot_answers_due.push_back(ring_predict(req_item));
            op_tally[req_item.op]++;
            issued_count++;
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            ring_slots_reg = csr_wdata;
            ring_front     = '0;
            ring_back      = '0;
            foreach (ring_written[k]) ring_written[k] = 1'b0;
            csr_writes++;
            nxt_csr = 1'b0;
         end
         answers_left = issued_count - answered_count - (rsp_strobe ? 1 : 0);
         if (!nxt_start && !nxt_csr && ops_to_send.size() != 0) begin
            case (ops_to_send[0].kind)
               PEND_ITEM: begin
                  if (hold_count < ops_to_send[0].hold) begin
                     hold_count++;
                  end else begin
                     req_item <= ops_to_send[0].req;
                     nxt_start  = 1'b1;
                     hold_count = 0;
                     void'(ops_to_send.pop_front());
                  end
               end
               PEND_CSR: begin
                  if (answers_left <= 0 && !busy) begin
                     csr_wdata <= ops_to_send[0].csr_value;
                     nxt_csr = 1'b1;
                     void'(ops_to_send.pop_front());
                  end
               end
               default: begin
                  if (answers_left <= 0) void'(ops_to_send.pop_front());
               end
            endcase
         end
      end
      start     <= nxt_start;
      csr_valid <= nxt_csr;
   end

   always @(posedge clock) begin
      rrsl_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (slot_answers_due.size() == 0) begin
            $error("unexpected result: found %0b slot %0d", rsp_item.found, rsp_item.slot);
            mismatch_count++;
         end else begin
            want = slot_answers_due.pop_front();
            if (rsp_item.found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_item.found);
               mismatch_count++;
            end
            if (rsp_item.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_item.slot);
               mismatch_count++;
            end
            if (want.found) hit_count++;
         end
         answered_count <= answered_count + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  slot_answers_due.size());
         $display("retransmit_ring_seqno_lookup_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      // Empty ring at the reset slot count, then the sequence space wrapping through zero.
      queue_op(rrsl_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'h0000);
      queue_op(rrsl_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
      queue_op(rrsl_pkg::OP_APPEND, 32'hFFFF_FFFE, 16'h0000);
      queue_op(rrsl_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
      queue_op(rrsl_pkg::OP_APPEND, 32'h0000_0000, 16'h0000);
      queue_op(rrsl_pkg::OP_APPEND, 32'h0000_0001, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'hFFFF_FFFD, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'h0000_0005, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'h7FFF_FFFD, 16'h0000);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'd3);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'd4);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'hFFFF);
      queue_drain();
      // Two slots: the second append drops the first, leaving one live slot.
      queue_csr(7'd2);
      queue_op(rrsl_pkg::OP_APPEND, 32'd10, 16'h0000);
      queue_op(rrsl_pkg::OP_APPEND, 32'd11, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'd11, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'd10, 16'h0000);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'd0);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'd1);
      // A zero slot count acts as one, so the ring never holds anything.
      queue_csr(7'd0);
      queue_op(rrsl_pkg::OP_APPEND, 32'd7, 16'h0000);
      queue_op(rrsl_pkg::OP_LOOKUP, 32'd7, 16'h0000);
      queue_op(rrsl_pkg::OP_GET, 32'h0000_0000, 16'd0);

      fill_phase(64, 130);
      fill_phase(1, 45);
      fill_phase(2, 50);
      fill_phase(127, 50);
      fill_phase(65, 50);
      fill_phase(0, 45);
      fill_phase($urandom_range(3, 12), 55);
      fill_phase($urandom_range(1, 127), 50);
      allow_idle = 1'b0;
      fill_phase($urandom_range(3, 8), 55);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (ops_to_send.size() != 0 || start || csr_valid || slot_answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d appends, %0d offset reads, %0d lookups, %0d unknown",
               answered_count, op_tally[rrsl_pkg::OP_APPEND], op_tally[rrsl_pkg::OP_GET],
               op_tally[rrsl_pkg::OP_LOOKUP], op_tally[rrsl_pkg::OP_NONE]);
      $display("%0d hits, %0d slot count writes from 0 through 127", hit_count, csr_writes);
      if (mismatch_count == 0 && slot_answers_due.size() == 0) begin
         $display("retransmit_ring_seqno_lookup_unit_tb: clean");
      end else begin
         $display("retransmit_ring_seqno_lookup_unit_tb: errors");
      end
      $finish;
   end

endmodule
